FILE: hw/rtl/kcl_pkg.sv
// Shared constants and types for the keypad code lock.
`default_nettype none

package kcl_pkg;

    localparam int MAX_CODE_KEYS = 10;
    localparam int KEY_BITS      = 8;
    localparam int MASTER_KEYS   = 10;
    localparam int RESET_LEN     = 4;

    localparam int CNT_TOP  = (MAX_CODE_KEYS > MASTER_KEYS) ? MAX_CODE_KEYS : MASTER_KEYS;
    localparam int CNT_W    = $clog2(CNT_TOP + 1);
    localparam int ADDR_W   = $clog2(MAX_CODE_KEYS);
    localparam int LEN_W    = $clog2(MAX_CODE_KEYS + 1);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [LEN_W-1:0]    len_t;

    localparam key_t K_ZERO  = key_t'(8'h30);
    localparam key_t K_SLASH = key_t'(8'h2f);
    localparam key_t K_DASH  = key_t'(8'h2d);
    localparam key_t K_STAR  = key_t'(8'h2a);

    localparam logic [2:0] FAIL_SAT = 3'd7;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NORMAL,
        MODE_OPEN,
        MODE_MASTER,
        MODE_CHECK,
        MODE_NEW,
        MODE_LOCKOUT
    } mode_t;

    typedef enum logic [3:0] {
        ST_IGNORED      = 4'd0,
        ST_KEY_TAKEN    = 4'd1,
        ST_WRONG        = 4'd2,
        ST_OPENED       = 4'd3,
        ST_CLOSED       = 4'd4,
        ST_LOCK_START   = 4'd5,
        ST_LOCK_TICK    = 4'd6,
        ST_LOCK_OVER    = 4'd7,
        ST_MASTER_RESET = 4'd8,
        ST_MODE_ENTERED = 4'd9,
        ST_CHANGED      = 4'd10
    } status_t;

    typedef enum logic [0:0] {
        OP_KEY  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_MAX_TRIES     = 1'b0,
        REG_LOCKOUT_TICKS = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/keypad_code_lock_unit.sv
// Keypad code lock: top level with code memory, sequencer and APB registers.
//
// Each beat on the input stream is a key press (s_tuser low, ASCII key in s_tdata)
// or a one-second tick (s_tuser high); each beat yields exactly one result beat.
// The stored code key for the current entry position is read from a registered code
// memory the cycle before it is needed, so a new beat is taken every cycle while the
// result register drains or is taken. After reset the code is "0000" (a default
// flag stands in for the memory contents until a new code is written); no clearing
// pass is needed.
`default_nettype none

module keypad_code_lock_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_code
    input  wire logic        s_tuser,   // [0] op
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] status, [4] lock_open,
                                        // [12:5] lockout_left, [16:13] keys_entered
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import kcl_pkg::*;

    // configuration
    logic [2:0] max_tries_reg;
    logic [7:0] lockout_ticks_reg;

    // state
    mode_t      mode_reg, mode_next;
    cnt_t       entry_reg, entry_next;
    logic       mis_reg, mis_next;
    logic [2:0] fail_reg, fail_next;
    logic [7:0] lock_reg, lock_next;
    len_t       len_reg, len_next;
    logic       dflt_reg, dflt_next;

    // code memory
    key_t       code_mem [MAX_CODE_KEYS];
    key_t       rd_reg;
    logic       wr_en;
    addr_t      wr_addr;
    addr_t      rd_addr;

    // result register
    logic       out_valid_reg;
    status_t    status_reg, status_next;
    logic       open_reg;
    logic [7:0] left_reg;
    cnt_t       keys_reg;

    logic       accept;
    logic       is_tick;
    key_t       key;
    key_t       ref_key;
    key_t       master_key;
    cnt_t       take_idx;
    logic       take_mis;
    logic       take_done;
    logic       do_normal;
    logic [2:0] fail_inc;
    logic       cfg_wr;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == OP_TICK);
    assign key      = s_tdata[KEY_BITS-1:0];

    assign ref_key    = dflt_reg ? K_ZERO : rd_reg;
    assign master_key = key_t'(K_ZERO + key_t'(entry_reg));
    assign fail_inc   = (fail_reg < FAIL_SAT) ? fail_reg + 3'd1 : fail_reg;

    // Compare one key against the stored code at the current position.
    always_comb begin
        take_idx = entry_reg;
        take_mis = mis_reg;
        if ((entry_reg < cnt_t'(len_reg)) && (entry_reg < cnt_t'(MAX_CODE_KEYS))) begin
            if (key != ref_key) begin
                take_mis = 1'b1;
            end
            take_idx = entry_reg + cnt_t'(1);
        end
        take_done = (take_idx >= cnt_t'(len_reg));
    end

    always_comb begin
        mode_next   = mode_reg;
        entry_next  = entry_reg;
        mis_next    = mis_reg;
        fail_next   = fail_reg;
        lock_next   = lock_reg;
        len_next    = len_reg;
        dflt_next   = dflt_reg;
        status_next = ST_IGNORED;
        wr_en       = 1'b0;
        do_normal   = 1'b0;

        if (accept) begin
            if (is_tick) begin
                if (mode_reg == MODE_LOCKOUT) begin
                    if (lock_reg <= 8'd1) begin
                        lock_next   = 8'd0;
                        mode_next   = MODE_IDLE;
                        status_next = ST_LOCK_OVER;
                    end else begin
                        lock_next   = lock_reg - 8'd1;
                        status_next = ST_LOCK_TICK;
                    end
                end
            end else begin
                unique case (mode_reg)
                    MODE_IDLE: begin
                        if (key == K_DASH) begin
                            mode_next   = MODE_MASTER;
                            entry_next  = '0;
                            mis_next    = 1'b0;
                            status_next = ST_MODE_ENTERED;
                        end else if (key == K_SLASH) begin
                            mode_next   = MODE_CHECK;
                            entry_next  = '0;
                            mis_next    = 1'b0;
                            status_next = ST_MODE_ENTERED;
                        end else begin
                            do_normal = 1'b1;
                        end
                    end
                    MODE_NORMAL: begin
                        do_normal = 1'b1;
                    end
                    MODE_OPEN: begin
                        if (key == K_STAR) begin
                            mode_next   = MODE_IDLE;
                            status_next = ST_CLOSED;
                        end
                    end
                    MODE_MASTER: begin
                        if (key == K_DASH) begin
                            entry_next  = '0;
                            mis_next    = 1'b0;
                            mode_next   = MODE_IDLE;
                            status_next = ST_WRONG;
                        end else if (entry_reg + cnt_t'(1) < cnt_t'(MASTER_KEYS)) begin
                            mis_next    = mis_reg || (key != master_key);
                            entry_next  = entry_reg + cnt_t'(1);
                            status_next = ST_KEY_TAKEN;
                        end else begin
                            entry_next = '0;
                            mode_next  = MODE_IDLE;
                            mis_next   = 1'b0;
                            if (mis_reg || (key != master_key)) begin
                                status_next = ST_WRONG;
                            end else begin
                                len_next    = len_t'(RESET_LEN);
                                dflt_next   = 1'b1;
                                status_next = ST_MASTER_RESET;
                            end
                        end
                    end
                    MODE_CHECK: begin
                        if ((entry_reg == '0) && (key == K_SLASH)) begin
                            mode_next   = MODE_IDLE;
                            mis_next    = 1'b0;
                            status_next = ST_KEY_TAKEN;
                        end else if (!take_done) begin
                            entry_next  = take_idx;
                            mis_next    = take_mis;
                            status_next = ST_KEY_TAKEN;
                        end else begin
                            entry_next = '0;
                            mis_next   = 1'b0;
                            if (take_mis) begin
                                status_next = ST_WRONG;
                            end else begin
                                mode_next   = MODE_NEW;
                                status_next = ST_MODE_ENTERED;
                            end
                        end
                    end
                    MODE_NEW: begin
                        if ((key != K_SLASH)
                                && (entry_reg + cnt_t'(1) < cnt_t'(MAX_CODE_KEYS))) begin
                            wr_en       = 1'b1;
                            dflt_next   = 1'b0;
                            entry_next  = entry_reg + cnt_t'(1);
                            status_next = ST_KEY_TAKEN;
                        end else begin
                            if (key != K_SLASH) begin
                                wr_en     = (entry_reg < cnt_t'(MAX_CODE_KEYS));
                                dflt_next = 1'b0;
                                len_next  = len_t'(entry_reg + cnt_t'(1));
                            end else begin
                                len_next = len_t'(entry_reg);
                            end
                            entry_next  = '0;
                            mode_next   = MODE_IDLE;
                            status_next = ST_CHANGED;
                        end
                    end
                    MODE_LOCKOUT: begin
                        status_next = ST_IGNORED;
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                    end
                endcase

                if (do_normal) begin
                    if (!take_done) begin
                        mode_next   = MODE_NORMAL;
                        entry_next  = take_idx;
                        mis_next    = take_mis;
                        status_next = ST_KEY_TAKEN;
                    end else begin
                        entry_next = '0;
                        mis_next   = 1'b0;
                        if (!take_mis) begin
                            mode_next   = MODE_OPEN;
                            status_next = ST_OPENED;
                        end else if (fail_inc >= max_tries_reg) begin
                            fail_next   = 3'd0;
                            lock_next   = lockout_ticks_reg;
                            mode_next   = MODE_LOCKOUT;
                            status_next = ST_LOCK_START;
                        end else begin
                            fail_next   = fail_inc;
                            mode_next   = MODE_IDLE;
                            status_next = ST_WRONG;
                        end
                    end
                end
            end
        end
    end

    // Prefetch the code key for the position the next beat will compare.
    assign wr_addr = entry_reg[ADDR_W-1:0];
    assign rd_addr = entry_next[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            code_mem[wr_addr] <= key;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_reg <= key;
        end else if (entry_next < cnt_t'(MAX_CODE_KEYS)) begin
            rd_reg <= code_mem[rd_addr];
        end else begin
            rd_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            entry_reg <= '0;
            mis_reg   <= 1'b0;
            fail_reg  <= 3'd0;
            lock_reg  <= 8'd0;
            len_reg   <= len_t'(RESET_LEN);
            dflt_reg  <= 1'b1;
        end else begin
            mode_reg  <= mode_next;
            entry_reg <= entry_next;
            mis_reg   <= mis_next;
            fail_reg  <= fail_next;
            lock_reg  <= lock_next;
            len_reg   <= len_next;
            dflt_reg  <= dflt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            open_reg   <= (mode_next == MODE_OPEN);
            left_reg   <= lock_next;
            keys_reg   <= entry_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, keys_reg[3:0], left_reg, open_reg, status_reg};

    // APB registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tries_reg     <= 3'd3;
            lockout_ticks_reg <= 8'd10;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_MAX_TRIES:     max_tries_reg     <= pwdata[2:0];
                REG_LOCKOUT_TICKS: lockout_ticks_reg <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_MAX_TRIES:     prdata = {29'd0, max_tries_reg};
            REG_LOCKOUT_TICKS: prdata = {24'd0, lockout_ticks_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // checks
    a_lock_only_in_lockout: assert property (@(posedge aclk) disable iff (!aresetn)
        (lock_reg != 8'd0) |-> (mode_reg == MODE_LOCKOUT))
        else $error("lockout count set outside lockout");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> ((entry_reg == '0) && !mis_reg))
        else $error("entry state not cleared at idle");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_t'(len_reg) <= cnt_t'(MAX_CODE_KEYS))
        else $error("code length out of range");

    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_tick && (mode_reg == MODE_OPEN) && (key == K_STAR))
            |=> (mode_reg == MODE_IDLE))
        else $error("star did not close the lock");

endmodule

`default_nettype wire

FILE: tb/keypad_code_lock_checker.sv
// Checker for the keypad code lock: mirrors the lock state and scores every result beat.
`timescale 1ns / 1ps

module keypad_code_lock_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_code
    input  wire logic        s_tuser,   // [0] op
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // [3:0] status, [4] lock_open,
                                        // [12:5] lockout_left, [16:13] keys_entered
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               error_count,
    output int               awaiting,
    output int               taken_beats,
    output kcl_pkg::mode_t   lock_mode,
    output logic [kcl_pkg::MAX_CODE_KEYS*kcl_pkg::KEY_BITS-1:0] code_keys,
    output logic [3:0]       code_len
);
    import kcl_pkg::*;

    // packed from the top bit down, so status lands in the lowest bits
    typedef struct packed {
        logic [3:0] keys_entered;
        logic [7:0] lockout_left;
        logic       lock_open;
        logic [3:0] status;
    } lock_result_t;

    lock_result_t expected_q[$];
    lock_result_t want;
    lock_result_t got;

    logic [2:0] tries_limit;
    logic [7:0] tick_limit;
    mode_t      lock_state;
    key_t       code_mem [MAX_CODE_KEYS];
    int         code_count;
    int         entry_pos;
    bit         mismatch;
    int         wrong_tries;
    int         ticks_left;

    // Compare one key against the stored code; true once the entry is complete.
    function automatic bit compare_code_key(input key_t key);
        if (entry_pos < code_count && entry_pos < MAX_CODE_KEYS) begin
            if (key != code_mem[entry_pos])
                mismatch = 1'b1;
            entry_pos++;
        end
        return entry_pos >= code_count;
    endfunction

    function automatic status_t entry_key(input key_t key);
        if (!compare_code_key(key))
            return ST_KEY_TAKEN;
        entry_pos = 0;
        if (!mismatch) begin
            lock_state = MODE_OPEN;
            return ST_OPENED;
        end
        mismatch = 1'b0;
        if (wrong_tries < 7)
            wrong_tries++;
        if (wrong_tries >= tries_limit) begin
            wrong_tries = 0;
            ticks_left  = tick_limit;
            lock_state  = MODE_LOCKOUT;
            return ST_LOCK_START;
        end
        lock_state = MODE_IDLE;
        return ST_WRONG;
    endfunction

    function automatic status_t verify_key(input key_t key);
        // slash as the very first key backs out of the code change
        if (entry_pos == 0 && key == K_SLASH) begin
            lock_state = MODE_IDLE;
            mismatch   = 1'b0;
            return ST_KEY_TAKEN;
        end
        if (!compare_code_key(key))
            return ST_KEY_TAKEN;
        entry_pos = 0;
        if (mismatch) begin
            mismatch = 1'b0;
            return ST_WRONG;
        end
        lock_state = MODE_NEW;
        return ST_MODE_ENTERED;
    endfunction

    function automatic status_t master_key(input key_t key);
        if (key == K_DASH) begin
            entry_pos  = 0;
            mismatch   = 1'b0;
            lock_state = MODE_IDLE;
            return ST_WRONG;
        end
        if (key != key_t'(K_ZERO + entry_pos))
            mismatch = 1'b1;
        entry_pos++;
        if (entry_pos < MASTER_KEYS)
            return ST_KEY_TAKEN;
        entry_pos  = 0;
        lock_state = MODE_IDLE;
        if (mismatch) begin
            mismatch = 1'b0;
            return ST_WRONG;
        end
        for (int k = 0; k < MAX_CODE_KEYS; k++)
            code_mem[k] = (k < RESET_LEN) ? K_ZERO : key_t'(0);
        code_count = RESET_LEN;
        return ST_MASTER_RESET;
    endfunction

    function automatic status_t store_key(input key_t key);
        if (key != K_SLASH) begin
            if (entry_pos < MAX_CODE_KEYS)
                code_mem[entry_pos] = key;
            entry_pos++;
            if (entry_pos < MAX_CODE_KEYS)
                return ST_KEY_TAKEN;
        end
        code_count = entry_pos;
        entry_pos  = 0;
        lock_state = MODE_IDLE;
        return ST_CHANGED;
    endfunction

    function automatic lock_result_t predict_lock_beat(input op_t op, input key_t key);
        status_t      st;
        lock_result_t r;
        st = ST_IGNORED;
        if (op == OP_TICK) begin
            if (lock_state == MODE_LOCKOUT) begin
                if (ticks_left <= 1) begin
                    ticks_left = 0;
                    lock_state = MODE_IDLE;
                    st = ST_LOCK_OVER;
                end else begin
                    ticks_left--;
                    st = ST_LOCK_TICK;
                end
            end
        end else begin
            case (lock_state)
                MODE_IDLE: begin
                    entry_pos = 0;
                    mismatch  = 1'b0;
                    if (key == K_DASH) begin
                        lock_state = MODE_MASTER;
                        st = ST_MODE_ENTERED;
                    end else if (key == K_SLASH) begin
                        lock_state = MODE_CHECK;
                        st = ST_MODE_ENTERED;
                    end else begin
                        lock_state = MODE_NORMAL;
                        st = entry_key(key);
                    end
                end
                MODE_NORMAL: st = entry_key(key);
                MODE_OPEN: begin
                    if (key == K_STAR) begin
                        lock_state = MODE_IDLE;
                        st = ST_CLOSED;
                    end
                end
                MODE_MASTER: st = master_key(key);
                MODE_CHECK:  st = verify_key(key);
                MODE_NEW:    st = store_key(key);
                default: ;
            endcase
        end
        r.status       = st;
        r.lock_open    = (lock_state == MODE_OPEN);
        r.lockout_left = 8'(ticks_left);
        r.keys_entered = 4'(entry_pos);
        return r;
    endfunction

    task automatic check_field(input string field, input int expected_val, input int actual_val);
        if (expected_val != actual_val) begin
            $error("%s mismatch: expected %0d, got %0d", field, expected_val, actual_val);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tries_limit = 3'd3;
            tick_limit  = 8'd10;
            lock_state  = MODE_IDLE;
            for (int k = 0; k < MAX_CODE_KEYS; k++)
                code_mem[k] = (k < RESET_LEN) ? K_ZERO : key_t'(0);
            code_count  = RESET_LEN;
            entry_pos   = 0;
            mismatch    = 1'b0;
            wrong_tries = 0;
            ticks_left  = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    {REG_MAX_TRIES, 2'b00}:     tries_limit = pwdata[2:0];
                    {REG_LOCKOUT_TICKS, 2'b00}: tick_limit  = pwdata[7:0];
                    default: ;
                endcase
            end
            // predict before scoring so a same-edge result still finds its entry
            if (s_tvalid && s_tready) begin
                want = predict_lock_beat(op_t'(s_tuser), s_tdata);
                expected_q.push_back(want);
                if (want.status != ST_IGNORED)
                    taken_beats++;
            end
            if (m_tvalid && m_tready) begin
                got = lock_result_t'(m_tdata[16:0]);
                if (expected_q.size() == 0) begin
                    $error("result beat with no expectation waiting: status %0d", got.status);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("lock_open", want.lock_open, got.lock_open);
                    check_field("lockout_left", want.lockout_left, got.lockout_left);
                    check_field("keys_entered", want.keys_entered, got.keys_entered);
                end
            end
        end
        awaiting  = expected_q.size();
        lock_mode = lock_state;
        for (int k = 0; k < MAX_CODE_KEYS; k++)
            code_keys[k*KEY_BITS +: KEY_BITS] = code_mem[k];
        code_len = 4'(code_count);
    end

endmodule

FILE: tb/testbench.sv
// Top of the keypad code lock testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;

    import kcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] key_code
    logic        s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [3:0] status, [4] lock_open, [12:5] lockout_left,
                            // [16:13] keys_entered
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          awaiting;
    int          taken_beats;
    mode_t       lock_mode;
    logic [MAX_CODE_KEYS*KEY_BITS-1:0] code_keys;
    logic [3:0]  code_len;

    bit          sender_steady;
    int          total_beats;
    int          settings;
    int          quiet_cycles;

    keypad_code_lock_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    keypad_code_lock_checker lock_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .error_count(error_count), .awaiting(awaiting), .taken_beats(taken_beats),
        .lock_mode(lock_mode), .code_keys(code_keys), .code_len(code_len)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic key_t any_key();
        return key_t'($urandom_range(0, 255));
    endfunction

    // A key that cannot switch an idle lock into master reset or code change.
    function automatic key_t free_key();
        key_t k;
        do
            k = any_key();
        while (k == K_DASH || k == K_SLASH);
        return k;
    endfunction

    function automatic key_t other_key(input key_t k, input bit first);
        key_t r;
        do
            r = any_key();
        while (r == k || (first && (r == K_DASH || r == K_SLASH)));
        return r;
    endfunction

    // All stimulus tasks start and end just after a falling edge.
    task automatic push_beat(input op_t op, input key_t key);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = key;
        do
            @(posedge aclk);
        while (!s_tready);
        total_beats++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold the sender until every result is back, then let the block settle.
    task automatic settle();
        s_tvalid = 1'b0;
        while (awaiting != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic enter_code(input bit wrong);
        int   n;
        int   bad;
        key_t k;
        n = code_len;
        if (n == 0) begin
            push_beat(OP_KEY, free_key());
            return;
        end
        bad = wrong ? $urandom_range(0, n - 1) : -1;
        for (int p = 0; p < n; p++) begin
            k = code_keys[p*KEY_BITS +: KEY_BITS];
            if (p == bad)
                k = other_key(k, p == 0);
            push_beat(OP_KEY, k);
        end
    endtask

    task automatic change_code();
        int   r;
        int   new_len;
        bit   wrong;
        key_t k;
        push_beat(OP_KEY, K_SLASH);
        if ($urandom_range(0, 9) == 0) begin
            push_beat(OP_KEY, K_SLASH);
            return;
        end
        wrong = ($urandom_range(0, 4) == 0);
        enter_code(wrong);
        // back out after a failed attempt at the current code
        if (wrong) begin
            push_beat(OP_KEY, K_SLASH);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 8)
            new_len = 0;
        else if (r < 16)
            new_len = MAX_CODE_KEYS;
        else
            new_len = $urandom_range(1, 6);
        for (int p = 0; p < new_len; p++) begin
            k = (p == 0) ? free_key() : other_key(K_SLASH, 1'b0);
            push_beat(OP_KEY, k);
        end
        if (new_len < MAX_CODE_KEYS)
            push_beat(OP_KEY, K_SLASH);
    endtask

    task automatic master_reset();
        int   r;
        int   bad;
        key_t k;
        r   = $urandom_range(0, 9);
        bad = (r < 6) ? -1 : $urandom_range(0, MASTER_KEYS - 1);
        push_beat(OP_KEY, K_DASH);
        for (int p = 0; p < MASTER_KEYS; p++) begin
            k = key_t'(K_ZERO + p);
            if (p == bad) begin
                if (r == 9) begin
                    push_beat(OP_KEY, K_DASH);
                    return;
                end
                k = other_key(k, 1'b0);
            end
            push_beat(OP_KEY, k);
        end
    endtask

    task automatic drive_sequence();
        int r;
        r = $urandom_range(0, 99);
        case (lock_mode)
            MODE_LOCKOUT: begin
                if (r < 10)
                    push_beat(OP_KEY, any_key());
                else
                    push_beat(OP_TICK, any_key());
            end
            MODE_OPEN: begin
                if (r < 20)
                    push_beat(OP_KEY, any_key());
                else if (r < 30)
                    push_beat(OP_TICK, any_key());
                else
                    push_beat(OP_KEY, K_STAR);
            end
            MODE_IDLE: begin
                if (r < 30)
                    enter_code(1'b0);
                else if (r < 50)
                    enter_code(1'b1);
                else if (r < 65)
                    change_code();
                else if (r < 77)
                    master_reset();
                else if (r < 90) begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1) == 0)
                            push_beat(OP_TICK, any_key());
                        else
                            push_beat(OP_KEY, any_key());
                    end
                end else begin
                    push_beat(OP_TICK, any_key());
                end
            end
            default: begin
                // finish whatever entry noise left open
                if (r < 80)
                    push_beat(OP_KEY, any_key());
                else
                    push_beat(OP_TICK, any_key());
            end
        endcase
    endtask

    task automatic run_phase(input logic [2:0] tries, input logic [7:0] ticks,
                             input int beats);
        int goal;
        settle();
        write_reg(REG_MAX_TRIES, 32'(tries));
        write_reg(REG_LOCKOUT_TICKS, 32'(ticks));
        settings++;
        goal = taken_beats + beats;
        while (taken_beats < goal) begin
            if ($urandom_range(0, 15) == 0)
                sender_steady = !sender_steady;
            if ($urandom_range(0, 199) == 0)
                settle();
            drive_sequence();
        end
    endtask

    initial begin
        int  stall;
        bit  steady;
        stall    = 0;
        steady   = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0)
                steady = !steady;
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if (!steady && $urandom_range(0, 99) < 25)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = OP_KEY;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        sender_steady = 1'b0;
        total_beats   = 0;
        settings      = 1;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset register values: idle tick, open, ignored key, close
        push_beat(OP_TICK, 8'hff);
        repeat (4) push_beat(OP_KEY, K_ZERO);
        push_beat(OP_KEY, 8'hff);
        push_beat(OP_KEY, K_STAR);
        // early dash aborts master reset, slash-slash cancels code change
        push_beat(OP_KEY, K_DASH);
        push_beat(OP_KEY, K_ZERO);
        push_beat(OP_KEY, K_DASH);
        push_beat(OP_KEY, K_SLASH);
        push_beat(OP_KEY, K_SLASH);

        // zero tries and zero ticks: one wrong entry locks, the next tick frees
        settle();
        write_reg(REG_MAX_TRIES, 32'd0);
        write_reg(REG_LOCKOUT_TICKS, 32'd0);
        settings++;
        push_beat(OP_KEY, 8'h00);
        repeat (3) push_beat(OP_KEY, K_ZERO);
        push_beat(OP_KEY, K_ZERO);
        push_beat(OP_TICK, 8'h00);
        // store an empty code, then any key opens at once
        push_beat(OP_KEY, K_SLASH);
        repeat (4) push_beat(OP_KEY, K_ZERO);
        push_beat(OP_KEY, K_SLASH);
        push_beat(OP_KEY, K_STAR);
        push_beat(OP_KEY, K_STAR);

        run_phase(3'd3, 8'd10, 130);
        run_phase(3'd7, 8'd1, 130);
        run_phase(3'd2, 8'd5, 130);
        run_phase(3'd0, 8'd0, 110);
        run_phase(3'd1, 8'd255, 200);
        run_phase(3'd5, 8'd2, 110);

        settle();
        $display("Drove %0d key and tick beats (%0d not ignored) under %0d register settings,",
                 total_beats, taken_beats, settings);
        $display("through entries, lockouts, code changes and master resets with stalls.");
        if (error_count == 0 && awaiting == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
